/* hdl/qppd_pkg.sv */
// Shared types and constants for the quadrature position PID drive.
package qppd_pkg;

	localparam int IN_DATA_W  = 16;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 80;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam int TARGET_W = 13;
	localparam int GAIN_W   = 16;
	localparam int DB_W     = 9;
	localparam int DUTY_W   = 9;
	localparam int DIR_W    = 2;
	localparam int POS_W    = 32;
	localparam int ILL_W    = 32;

	// output word layout
	localparam int DUTY_LSB = 0;
	localparam int DIR_LSB  = DUTY_LSB + DUTY_W;
	localparam int POS_LSB  = DIR_LSB + DIR_W;
	localparam int ILL_LSB  = POS_LSB + POS_W;
	localparam int OUT_USED = ILL_LSB + ILL_W;

	localparam int DEG_SCALE  = 45;
	localparam int EFFORT_MAX = 400;
	// floor(y/25) = (y * DIV25_MUL) >> DIV25_SHIFT for y below 10000
	localparam int DIV25_MUL   = 10486;
	localparam int DIV25_SHIFT = 18;

	localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

	localparam logic [1:0] CMD_SAMPLE = 2'd0;
	localparam logic [1:0] CMD_TICK   = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;

	localparam logic [1:0] DIR_STOP = 2'd0;
	localparam logic [1:0] DIR_FWD  = 2'd1;
	localparam logic [1:0] DIR_REV  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_I  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DB_UP   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DB_DOWN = 3'd4;

	typedef enum logic [2:0] {
		OP_NONE  = 3'd0,
		OP_UP    = 3'd1,
		OP_DOWN  = 3'd2,
		OP_BAD   = 3'd3,
		OP_TICK  = 3'd4,
		OP_CLEAR = 3'd5
	} op_t;

	// [last phase][new phase]
	localparam op_t STEP_TABLE [4][4] = '{
		'{OP_NONE, OP_DOWN, OP_UP,   OP_BAD },
		'{OP_UP,   OP_NONE, OP_BAD,  OP_DOWN},
		'{OP_DOWN, OP_BAD,  OP_NONE, OP_UP  },
		'{OP_BAD,  OP_UP,   OP_DOWN, OP_NONE}
	};

	typedef struct packed {
		op_t                        op;
		logic signed [TARGET_W-1:0] target;
	} qppd_entry_t;

	typedef struct packed {
		logic        valid;
		qppd_entry_t entry;
	} qppd_push_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qppd_q_stat_t;

	typedef struct packed {
		logic                  valid;
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} qppd_cfg_t;

endpackage

/* hdl/qppd_front.sv */
// Front end: takes input words, tracks encoder phase and classifies each word.
module qppd_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [qppd_pkg::IN_DATA_W-1:0] s_tdata,
	input  logic [qppd_pkg::IN_USER_W-1:0] s_tuser,
	input  qppd_pkg::qppd_q_stat_t       q_stat,
	output qppd_pkg::qppd_push_t         push
);
	import qppd_pkg::*;

	logic [1:0] last_phase_q;
	logic [1:0] phase;
	logic       accept;
	op_t        op;

	assign s_tready = !q_stat.full;
	assign accept   = s_tvalid && s_tready;
	assign phase    = {s_tdata[1], s_tdata[0]};

	always_comb begin
		unique case (s_tuser)
			CMD_SAMPLE: op = STEP_TABLE[last_phase_q][phase];
			CMD_TICK:   op = OP_TICK;
			CMD_CLEAR:  op = OP_CLEAR;
			default:    op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_phase_q <= 2'd0;
		end else if (accept && s_tuser == CMD_SAMPLE) begin
			last_phase_q <= phase;
		end
	end

	assign push.valid        = accept;
	assign push.entry.op     = op;
	assign push.entry.target = $signed(s_tdata[2 +: TARGET_W]);

endmodule

/* hdl/qppd_fifo.sv */
// Two-entry queue between front and back ends.
module qppd_fifo (
	input  logic                   clk,
	input  logic                   arst_n,
	input  qppd_pkg::qppd_push_t   push,
	input  logic                   pop,
	output qppd_pkg::qppd_entry_t  rd_entry,
	output qppd_pkg::qppd_q_stat_t q_stat
);
	import qppd_pkg::*;

	qppd_entry_t mem_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  cnt_q;

	assign q_stat.full  = (cnt_q == 2'd2);
	assign q_stat.empty = (cnt_q == 2'd0);
	assign rd_entry     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_ptr_q] <= push.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push.valid && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push.valid) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

/* hdl/qppd_back.sv */
// Back end: position and error counts, PID sequencer, duty mapping, result register.
module qppd_back #(
	parameter int COUNT_BITS = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  qppd_pkg::qppd_cfg_t             cfg,
	input  qppd_pkg::qppd_q_stat_t          q_stat,
	input  qppd_pkg::qppd_entry_t           rd_entry,
	output logic                            pop,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [qppd_pkg::OUT_DATA_W-1:0] m_tdata
);
	import qppd_pkg::*;

	localparam int EW    = ((COUNT_BITS > 32) ? COUNT_BITS : 32) + 1;
	localparam int ACC_W = 52;
	localparam int MUL_W = GAIN_W + 33;

	typedef enum logic [9:0] {
		ST_IDLE = 10'b00_0000_0001,
		ST_ERR  = 10'b00_0000_0010,
		ST_INT  = 10'b00_0000_0100,
		ST_MP   = 10'b00_0000_1000,
		ST_MI   = 10'b00_0001_0000,
		ST_MD   = 10'b00_0010_0000,
		ST_EFF  = 10'b00_0100_0000,
		ST_MAP1 = 10'b00_1000_0000,
		ST_MAP2 = 10'b01_0000_0000,
		ST_DONE = 10'b10_0000_0000
	} state_t;

	state_t st_q;

	logic signed [GAIN_W-1:0]     gain_p_q, gain_i_q, gain_d_q;
	logic [DB_W-1:0]              db_up_q, db_down_q;

	logic signed [COUNT_BITS-1:0] count_q;
	logic [ILL_W-1:0]             illegal_q;
	logic signed [31:0]           integral_q;
	logic signed [31:0]           prev_q;
	logic [DUTY_W-1:0]            held_duty_q;
	logic [DIR_W-1:0]             held_dir_q;

	logic signed [TARGET_W-1:0]   target_q;
	logic signed [31:0]           err_q;
	logic signed [32:0]           diff_q;
	logic signed [ACC_W-1:0]      acc_q;
	logic [DUTY_W-1:0]            mag_q;
	logic [DB_W-1:0]              db_q;
	logic [DIR_W-1:0]             dir_q;
	logic [17:0]                  prod_q;

	logic                         m_tvalid_q;
	logic [OUT_DATA_W-1:0]        m_tdata_q;

	logic signed [EW-1:0]         err_full;
	logic signed [31:0]           err_sat;
	logic signed [33:0]           int_full;
	logic signed [31:0]           int_sat;
	logic signed [GAIN_W-1:0]     mul_a;
	logic signed [32:0]           mul_b;
	logic signed [MUL_W-1:0]      mul_p;
	logic signed [ACC_W-1:0]      acc_adj;
	logic signed [ACC_W-1:0]      eff_full;
	logic signed [9:0]            eff_sat;
	logic [DUTY_W-1:0]            eff_mag;
	logic [DB_W-1:0]              db_up_c, db_down_c;
	logic [27:0]                  quo_full;
	logic [DUTY_W-1:0]            quo;

	assign pop      = (st_q == ST_IDLE) && !q_stat.empty;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	always_comb begin
		err_full = EW'(target_q) * $signed(EW'(DEG_SCALE)) + EW'(count_q);
		priority if (err_full > EW'(S32_MAX)) begin
			err_sat = S32_MAX;
		end else if (err_full < EW'(S32_MIN)) begin
			err_sat = S32_MIN;
		end else begin
			err_sat = 32'(err_full);
		end

		int_full = 34'(integral_q) + 34'(err_q);
		priority if (int_full > 34'(S32_MAX)) begin
			int_sat = S32_MAX;
		end else if (int_full < 34'(S32_MIN)) begin
			int_sat = S32_MIN;
		end else begin
			int_sat = 32'(int_full);
		end
	end

	always_comb begin
		unique case (st_q)
			ST_MI: begin
				mul_a = gain_i_q;
				mul_b = 33'(integral_q);
			end
			ST_MD: begin
				mul_a = gain_d_q;
				mul_b = diff_q;
			end
			default: begin
				mul_a = gain_p_q;
				mul_b = 33'(err_q);
			end
		endcase
		mul_p = MUL_W'(mul_a) * MUL_W'(mul_b);
	end

	// truncate toward zero, then clamp
	always_comb begin
		acc_adj  = acc_q + (acc_q[ACC_W-1] ? ACC_W'(255) : ACC_W'(0));
		eff_full = acc_adj >>> 8;
		priority if (eff_full > ACC_W'(EFFORT_MAX)) begin
			eff_sat = 10'(EFFORT_MAX);
		end else if (eff_full < ACC_W'(-EFFORT_MAX)) begin
			eff_sat = 10'(-EFFORT_MAX);
		end else begin
			eff_sat = 10'(eff_full);
		end
		eff_mag   = eff_sat[9] ? DUTY_W'(-eff_sat) : DUTY_W'(eff_sat);
		db_up_c   = (db_up_q > DB_W'(EFFORT_MAX)) ? DB_W'(EFFORT_MAX) : db_up_q;
		db_down_c = (db_down_q > DB_W'(EFFORT_MAX)) ? DB_W'(EFFORT_MAX) : db_down_q;
		quo_full  = 28'(prod_q[17:4]) * 28'(DIV25_MUL);
		quo       = quo_full[DIV25_SHIFT +: DUTY_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q  <= '0;
			gain_i_q  <= '0;
			gain_d_q  <= '0;
			db_up_q   <= '0;
			db_down_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_GAIN_P:  gain_p_q  <= $signed(cfg.data);
				REG_GAIN_I:  gain_i_q  <= $signed(cfg.data);
				REG_GAIN_D:  gain_d_q  <= $signed(cfg.data);
				REG_DB_UP:   db_up_q   <= cfg.data[DB_W-1:0];
				REG_DB_DOWN: db_down_q <= cfg.data[DB_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: target_q <= rd_entry.target;
			ST_ERR:  err_q    <= err_sat;
			ST_INT:  diff_q   <= 33'(err_q) - 33'(prev_q);
			ST_MP:   acc_q    <= ACC_W'(mul_p);
			ST_MI:   acc_q    <= acc_q - ACC_W'(mul_p);
			ST_MD:   acc_q    <= acc_q + ACC_W'(mul_p);
			ST_EFF: begin
				mag_q <= eff_mag;
				priority if (eff_sat == 10'sd0) begin
					db_q  <= '0;
					dir_q <= DIR_STOP;
				end else if (!eff_sat[9]) begin
					db_q  <= db_up_c;
					dir_q <= DIR_FWD;
				end else begin
					db_q  <= db_down_c;
					dir_q <= DIR_REV;
				end
			end
			ST_MAP1: prod_q <= 18'(mag_q) * 18'(DB_W'(EFFORT_MAX) - db_q);
			ST_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					m_tdata_q <= {(OUT_DATA_W - OUT_USED)'(0), illegal_q,
						POS_W'(count_q), held_dir_q, held_duty_q};
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			count_q     <= '0;
			illegal_q   <= '0;
			integral_q  <= '0;
			prev_q      <= '0;
			held_duty_q <= '0;
			held_dir_q  <= DIR_STOP;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready && st_q != ST_DONE) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (pop) begin
						st_q <= (rd_entry.op == OP_TICK) ? ST_ERR : ST_DONE;
						unique case (rd_entry.op)
							OP_UP:    count_q   <= count_q + COUNT_BITS'(1);
							OP_DOWN:  count_q   <= count_q - COUNT_BITS'(1);
							OP_BAD:   illegal_q <= illegal_q + ILL_W'(1);
							OP_CLEAR: count_q   <= '0;
							default: ;
						endcase
					end
				end
				ST_ERR: st_q <= ST_INT;
				ST_INT: begin
					integral_q <= int_sat;
					prev_q     <= err_q;
					st_q       <= ST_MP;
				end
				ST_MP:   st_q <= ST_MI;
				ST_MI:   st_q <= ST_MD;
				ST_MD:   st_q <= ST_EFF;
				ST_EFF:  st_q <= ST_MAP1;
				ST_MAP1: st_q <= ST_MAP2;
				ST_MAP2: begin
					held_duty_q <= db_q + quo;
					held_dir_q  <= dir_q;
					st_q        <= ST_DONE;
				end
				ST_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						st_q       <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* hdl/quadrature_position_pid_drive.sv */
// Quadrature position drive with PID control: top level.
//
// Input stream (s_*): one word per command. s_tuser carries the command
// (sample encoder, control tick, clear count); s_tdata carries the encoder
// channels and the target. Every input word gives exactly one output word
// on m_*: held duty, direction, position count and illegal-step count.
// Configuration writes (cfg_*) set the three Q8.8 gains and the two
// deadbands; cfg_ready is always high.
// Sample, clear and unused commands go from the queue straight to the
// result word; a control tick runs one shared 16x33 multiplier for the
// P, I and D terms (ST_MP, ST_MI, ST_MD), then maps effort to duty.
// The back end sequencer takes the next word only after it has loaded the
// last one's result word; a two-word queue lets input be taken while the
// back end works or the output waits.
// Reset clears counts, integral, gains, deadbands and held drive to zero.
// When m_tready is low the result word holds, the queue fills and
// s_tready drops.
module quadrature_position_pid_drive #(
	parameter int COUNT_BITS = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// enc_a [0], enc_b [1], target_degree [14:2], zero [15]
	input  logic [qppd_pkg::IN_DATA_W-1:0]  s_tdata,
	// cmd [1:0]
	input  logic [qppd_pkg::IN_USER_W-1:0]  s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// duty [8:0], direction [10:9], position [42:11], illegal_steps [74:43], zero [79:75]
	output logic [qppd_pkg::OUT_DATA_W-1:0] m_tdata,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [qppd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [qppd_pkg::CFG_DATA_W-1:0] cfg_data
);
	import qppd_pkg::*;

	qppd_push_t   push;
	qppd_q_stat_t q_stat;
	qppd_entry_t  rd_entry;
	qppd_cfg_t    cfg;
	logic         pop;

	assign cfg_ready = 1'b1;
	assign cfg.valid = cfg_valid;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	qppd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_stat   (q_stat),
		.push     (push)
	);

	qppd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.pop      (pop),
		.rd_entry (rd_entry),
		.q_stat   (q_stat)
	);

	qppd_back #(
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.q_stat   (q_stat),
		.rd_entry (rd_entry),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

/* hdl/qppd_checker.sv */
// Port-level checks for the drive, bound to the top level.
module qppd_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [qppd_pkg::OUT_DATA_W-1:0] m_tdata
);
	import qppd_pkg::*;

	logic [DUTY_W-1:0] duty;
	logic [DIR_W-1:0]  dir;

	assign duty = m_tdata[DUTY_LSB +: DUTY_W];
	assign dir  = m_tdata[DIR_LSB +: DIR_W];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output word changed while stalled");

	a_dir_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (dir == DIR_STOP || dir == DIR_FWD || dir == DIR_REV))
		else $error("bad direction code");

	a_duty_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> duty <= DUTY_W'(EFFORT_MAX))
		else $error("duty above full scale");

	a_stop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && dir == DIR_STOP |-> duty == '0)
		else $error("duty non-zero while stopped");

endmodule

bind quadrature_position_pid_drive qppd_checker u_qppd_checker (.*);

/* dv/qppd_tb_pkg.sv */
`timescale 1ns / 1ps
// Drive predictor and result scoreboard for the quadrature position PID drive testbench.
package qppd_tb_pkg;
	import qppd_pkg::*;

	localparam logic [1:0] CMD_SPARE = 2'd3;

	// next phase for one count up / one count down, indexed by the last phase
	localparam logic [1:0] PHASE_FWD [4] = '{2'd2, 2'd0, 2'd3, 2'd1};
	localparam logic [1:0] PHASE_REV [4] = '{2'd1, 2'd3, 2'd0, 2'd2};

	typedef struct packed {
		logic [ILL_W-1:0]  illegal;
		logic [POS_W-1:0]  pos;
		logic [DIR_W-1:0]  dir;
		logic [DUTY_W-1:0] duty;
	} drive_report_t;

	class drive_scoreboard;
		logic signed [GAIN_W-1:0] kp, ki, kd;
		logic [DB_W-1:0]          db_up, db_down;
		logic [1:0]               last_ph;
		logic [POS_W-1:0]         pos_cnt;
		logic [ILL_W-1:0]         bad_cnt;
		longint                   integ, prev_err;
		logic [DUTY_W-1:0]        duty;
		logic [DIR_W-1:0]         dir;
		drive_report_t            pending_reports[$];
		int                       mismatches, checked, ticks, samples, reg_writes;

		function new();
			kp = '0; ki = '0; kd = '0;
			db_up = '0; db_down = '0;
			last_ph = '0; pos_cnt = '0; bad_cnt = '0;
			integ = 0; prev_err = 0;
			duty = '0; dir = DIR_STOP;
			mismatches = 0; checked = 0; ticks = 0; samples = 0; reg_writes = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			reg_writes++;
			case (idx)
				REG_GAIN_P:  kp = val;
				REG_GAIN_I:  ki = val;
				REG_GAIN_D:  kd = val;
				REG_DB_UP:   db_up = val[DB_W-1:0];
				REG_DB_DOWN: db_down = val[DB_W-1:0];
				default: ;
			endcase
		endfunction

		function longint clamp_s32(longint v);
			if (v > longint'(S32_MAX))
				return longint'(S32_MAX);
			if (v < longint'(S32_MIN))
				return longint'(S32_MIN);
			return v;
		endfunction

		// deadband above full scale acts as full scale
		function logic [DUTY_W-1:0] scale_duty(longint mag, logic [DB_W-1:0] db);
			longint floor_db;
			floor_db = (longint'(db) > EFFORT_MAX) ? EFFORT_MAX : longint'(db);
			return DUTY_W'(floor_db + mag * (EFFORT_MAX - floor_db) / EFFORT_MAX);
		endfunction

		function void note_command(logic [1:0] cmd, logic [IN_DATA_W-1:0] word);
			logic [1:0]                 ph;
			logic signed [TARGET_W-1:0] tgt;
			longint                     e, acc, eff;
			drive_report_t              r;
			ph = word[1:0];
			tgt = word[TARGET_W+1:2];
			case (cmd)
				CMD_SAMPLE: begin
					samples++;
					if (ph != last_ph) begin
						if (ph == PHASE_FWD[last_ph])
							pos_cnt = pos_cnt + 1'b1;
						else if (ph == PHASE_REV[last_ph])
							pos_cnt = pos_cnt - 1'b1;
						else
							bad_cnt = bad_cnt + 1'b1;
					end
					last_ph = ph;
				end
				CMD_TICK: begin
					ticks++;
					e = clamp_s32(longint'(tgt) * DEG_SCALE + longint'($signed(pos_cnt)));
					integ = clamp_s32(integ + e);
					acc = longint'(kp) * e - longint'(ki) * integ
						+ longint'(kd) * (e - prev_err);
					eff = acc / 256;
					if (eff > EFFORT_MAX)
						eff = EFFORT_MAX;
					if (eff < -EFFORT_MAX)
						eff = -EFFORT_MAX;
					prev_err = e;
					if (eff == 0) begin
						duty = '0;
						dir = DIR_STOP;
					end else if (eff > 0) begin
						duty = scale_duty(eff, db_up);
						dir = DIR_FWD;
					end else begin
						duty = scale_duty(-eff, db_down);
						dir = DIR_REV;
					end
				end
				CMD_CLEAR: pos_cnt = '0;
				default: ;
			endcase
			r.duty = duty;
			r.dir = dir;
			r.pos = pos_cnt;
			r.illegal = bad_cnt;
			pending_reports.push_back(r);
		endfunction

		function void check_report(logic [OUT_DATA_W-1:0] word);
			drive_report_t got, want;
			got.duty = word[DUTY_LSB +: DUTY_W];
			got.dir = word[DIR_LSB +: DIR_W];
			got.pos = word[POS_LSB +: POS_W];
			got.illegal = word[ILL_LSB +: ILL_W];
			checked++;
			if (pending_reports.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected output word %h", word);
				return;
			end
			want = pending_reports.pop_front();
			if (got.duty !== want.duty || got.dir !== want.dir ||
					got.pos !== want.pos || got.illegal !== want.illegal) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected duty %0d dir %0d pos %0d illegal %0d, got duty %0d dir %0d pos %0d illegal %0d",
						want.duty, want.dir, $signed(want.pos), want.illegal,
						got.duty, got.dir, $signed(got.pos), got.illegal);
			end
		endfunction
	endclass

endpackage

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// Top-level testbench for the quadrature position PID drive.
module tb_top;
	import qppd_pkg::*;
	import qppd_tb_pkg::*;

	localparam int CYCLE_LIMIT       = 400000;
	localparam int RANDOM_SETTINGS   = 6;
	localparam int WORDS_PER_SETTING = 235;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid, s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic [IN_USER_W-1:0]  s_tuser;
	logic                  m_tvalid, m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_valid, cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	drive_scoreboard sb;
	logic            in_took = 1'b0;
	logic            cfg_took = 1'b0;
	logic            calm = 1'b0;
	int              cycles = 0;
	int              settings = 0;
	logic [1:0]      walk_ph;
	logic            walk_up;

	quadrature_position_pid_drive dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("status: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		in_took = s_tvalid && s_tready;
		cfg_took = cfg_valid && cfg_ready;
		if (in_took)
			sb.note_command(s_tuser, s_tdata);
		if (cfg_took)
			sb.write_reg(cfg_index, cfg_data);
		if (m_tvalid && m_tready)
			sb.check_report(m_tdata);
	end

	always @(negedge clk) begin
		m_tready <= calm || ($urandom_range(99) >= 14);
	end

	function automatic logic [GAIN_W-1:0] pick_gain();
		case ($urandom_range(7))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return '0;
			3: return GAIN_W'($urandom);
			default: return GAIN_W'($urandom_range(1023) - 512);
		endcase
	endfunction

	function automatic logic [DB_W-1:0] pick_db();
		case ($urandom_range(3))
			0: return '0;
			1: return DB_W'(EFFORT_MAX);
			2: return DB_W'($urandom_range(511));
			default: return DB_W'($urandom_range(EFFORT_MAX));
		endcase
	endfunction

	task automatic send_word(input logic [1:0] cmd, input logic [1:0] ph,
			input logic [TARGET_W-1:0] tgt);
		while (!calm && $urandom_range(99) < 14) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {1'b0, tgt, ph};
		do @(negedge clk); while (!in_took);
	endtask

	task automatic wait_idle;
		s_tvalid <= 1'b0;
		while (sb.pending_reports.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(negedge clk); while (!cfg_took);
	endtask

	task automatic configure(input logic [GAIN_W-1:0] p, input logic [GAIN_W-1:0] i,
			input logic [GAIN_W-1:0] d, input logic [DB_W-1:0] up, input logic [DB_W-1:0] down);
		wait_idle();
		write_reg(REG_GAIN_P, p);
		write_reg(REG_GAIN_I, i);
		write_reg(REG_GAIN_D, d);
		write_reg(REG_DB_UP, CFG_DATA_W'(up));
		write_reg(REG_DB_DOWN, CFG_DATA_W'(down));
		cfg_valid <= 1'b0;
		settings++;
	endtask

	task automatic random_word;
		int mode;
		logic [1:0] ph;
		mode = $urandom_range(99);
		if (mode < 58) begin
			if ($urandom_range(9) == 0)
				walk_up = ~walk_up;
			walk_ph = walk_up ? PHASE_FWD[walk_ph] : PHASE_REV[walk_ph];
			send_word(CMD_SAMPLE, walk_ph, TARGET_W'($urandom));
		end else if (mode < 80) begin
			if ($urandom_range(3) == 0)
				send_word(CMD_TICK, 2'($urandom), TARGET_W'($urandom));
			else
				send_word(CMD_TICK, 2'($urandom), TARGET_W'($urandom_range(16) - 8));
		end else if (mode < 85) begin
			send_word(CMD_CLEAR, 2'($urandom), TARGET_W'($urandom));
		end else if (mode < 95) begin
			ph = 2'($urandom);
			walk_ph = ph;
			send_word(CMD_SAMPLE, ph, TARGET_W'($urandom));
		end else begin
			send_word(CMD_SPARE, 2'($urandom), TARGET_W'($urandom));
		end
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		walk_ph = '0;
		walk_up = 1'b1;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: spare command, a full turn up, one down, double steps, clear, tick
		send_word(CMD_SPARE, 2'd3, 13'h1FFF);
		send_word(CMD_SAMPLE, 2'd2, 13'h1FFF);
		send_word(CMD_SAMPLE, 2'd3, '0);
		send_word(CMD_SAMPLE, 2'd1, 13'h0AAA);
		send_word(CMD_SAMPLE, 2'd0, 13'h1555);
		send_word(CMD_SAMPLE, 2'd1, '0);
		send_word(CMD_SAMPLE, 2'd2, '0);
		send_word(CMD_SAMPLE, 2'd1, '0);
		send_word(CMD_CLEAR, 2'd3, 13'h1FFF);
		send_word(CMD_TICK, 2'd3, 13'h0FFF);

		// extreme gains, saturated effort
		configure(16'h7FFF, 16'h8000, 16'h7FFF, DB_W'(EFFORT_MAX), '0);
		send_word(CMD_TICK, 2'd0, 13'h0FFF);
		send_word(CMD_TICK, 2'd0, 13'h1000);
		send_word(CMD_TICK, 2'd0, '0);
		send_word(CMD_SAMPLE, 2'd0, 13'h1FFF);

		// unity proportional gain, deadband above full scale forward
		configure(16'h0100, '0, '0, 9'h1FF, 9'd100);
		send_word(CMD_TICK, 2'd0, '0);
		send_word(CMD_TICK, 2'd0, 13'd1);
		send_word(CMD_TICK, 2'd0, 13'h1FFF);
		send_word(CMD_TICK, 2'd0, 13'd8);
		send_word(CMD_TICK, 2'd0, 13'h1FF7);

		// integral and negative derivative only
		configure('0, 16'h0100, 16'hFF00, '0, DB_W'(EFFORT_MAX));
		send_word(CMD_TICK, 2'd0, 13'd2);
		send_word(CMD_TICK, 2'd0, 13'h1FFD);
		send_word(CMD_TICK, 2'd0, '0);

		for (int s = 0; s < RANDOM_SETTINGS; s++) begin
			configure(pick_gain(), pick_gain(), pick_gain(), pick_db(), pick_db());
			calm = (s == 3);
			for (int n = 0; n < WORDS_PER_SETTING; n++)
				random_word();
		end

		wait_idle();
		calm = 1'b0;
		repeat (20) @(negedge clk);

		$display("drove %0d words: %0d encoder samples, %0d control ticks; %0d results compared",
			sb.checked, sb.samples, sb.ticks, sb.checked);
		$display("%0d register writes over %0d settings; %0d illegal transitions seen",
			sb.reg_writes, settings, sb.bad_cnt);
		if (sb.mismatches == 0 && sb.pending_reports.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d mismatches, %0d results outstanding",
				sb.mismatches, sb.pending_reports.size());
			$display("status: fail");
		end
		$finish;
	end

endmodule
